// ===== sv/stt_pkg.sv =====
// Shared types, codes and lookup tables for the source text tokenizer.
`timescale 1ns / 1ps

package stt_pkg;

  // Default width of the byte offset and length counters
  localparam int unsigned PositionWidthDefault = 16;

  // Keyword lookup
  localparam int unsigned NumKeywords = 5;
  localparam int unsigned KwRowLen    = 16;

  // Result queue between the scanner and the output port
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = QueuePtrW + 1;

  // Characters with a role of their own
  localparam logic [7:0] ChrNul     = 8'h00;
  localparam logic [7:0] ChrNewline = 8'h0A;
  localparam logic [7:0] ChrQuote   = 8'h22;
  localparam logic [7:0] ChrSlash   = 8'h2F;

  typedef enum logic [4:0] {
    KIND_UNKNOWN      = 5'd0,
    KIND_END          = 5'd1,
    KIND_KW_INT       = 5'd2,
    KIND_KW_CONSOLE   = 5'd3,
    KIND_KW_WRITELINE = 5'd4,
    KIND_KW_IF        = 5'd5,
    KIND_KW_WHILE     = 5'd6,
    KIND_IDENT        = 5'd7,
    KIND_STRING       = 5'd8,
    KIND_NUMBER       = 5'd9,
    KIND_PLUS         = 5'd10,
    KIND_MINUS        = 5'd11,
    KIND_SEMI         = 5'd12,
    KIND_ASSIGN       = 5'd13,
    KIND_DOT          = 5'd14,
    KIND_LPAREN       = 5'd15,
    KIND_RPAREN       = 5'd16,
    KIND_LBRACE       = 5'd17,
    KIND_RBRACE       = 5'd18
  } tok_kind_e;

  // Scanner mode, one-hot
  typedef enum logic [5:0] {
    MODE_IDLE    = 6'b000001,
    MODE_SLASH   = 6'b000010,
    MODE_COMMENT = 6'b000100,
    MODE_IDENT   = 6'b001000,
    MODE_NUMBER  = 6'b010000,
    MODE_STRING  = 6'b100000
  } scan_mode_e;

  typedef struct packed {
    tok_kind_e   kind;
    logic [15:0] start;
    logic [15:0] length;
    logic        last;
  } token_t;

  // Keyword text, padded with zeros to a full row
  localparam logic [7:0] KwText [NumKeywords][KwRowLen] = '{
    '{"i", "n", "t", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0,
      8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
    '{"C", "o", "n", "s", "o", "l", "e", 8'h0,
      8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
    '{"W", "r", "i", "t", "e", "L", "i", "n",
      "e", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
    '{"i", "f", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0,
      8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
    '{"w", "h", "i", "l", "e", 8'h0, 8'h0, 8'h0,
      8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0}
  };

  localparam logic [3:0] KwLen [NumKeywords] = '{4'd3, 4'd7, 4'd9, 4'd2, 4'd5};

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  // Keywords whose text holds byte c at index idx; short is low when the
  // index lies beyond every keyword row
  function automatic logic [NumKeywords-1:0] kw_keep(input logic [7:0] c,
                                                     input logic [3:0] idx,
                                                     input logic       short);
    logic [NumKeywords-1:0] keep;
    keep = '0;
    for (int i = 0; i < NumKeywords; i++) begin
      keep[i] = short && (idx < KwLen[i]) && (KwText[i][idx] == c);
    end
    return keep;
  endfunction

  // Kind of a closing identifier: first keyword still matching at full length
  function automatic tok_kind_e ident_kind(input logic [NumKeywords-1:0] mask,
                                           input logic [3:0]             len,
                                           input logic                   short);
    tok_kind_e kind;
    kind = KIND_IDENT;
    for (int i = NumKeywords - 1; i >= 0; i--) begin
      if (mask[i] && short && (len == KwLen[i])) begin
        kind = tok_kind_e'(5'(KIND_KW_INT) + 5'(i));
      end
    end
    return kind;
  endfunction

  // Single-character symbols; anything else is unknown
  function automatic tok_kind_e sym_kind(input logic [7:0] c);
    tok_kind_e kind;
    unique case (c)
      "+":     kind = KIND_PLUS;
      "-":     kind = KIND_MINUS;
      ";":     kind = KIND_SEMI;
      "=":     kind = KIND_ASSIGN;
      ".":     kind = KIND_DOT;
      "(":     kind = KIND_LPAREN;
      ")":     kind = KIND_RPAREN;
      "{":     kind = KIND_LBRACE;
      "}":     kind = KIND_RBRACE;
      default: kind = KIND_UNKNOWN;
    endcase
    return kind;
  endfunction

endpackage

// ===== sv/source_text_tokenizer_core.sv =====
// Source text tokenizer: one byte in per cycle while the result queue has room, tokens out through a queue.
// A token closed by a byte enters the result queue at that byte's transfer.
// Throughput: one byte per cycle while the output keeps up; a byte that yields two
//   tokens takes two queue entries, each read in its own transfer. Input is ready
//   while the four-entry result queue holds at most two tokens.
// Reset: rst_ni clears mode, offsets and length, sets the keyword mask, empties the queue.
`timescale 1ns / 1ps

module source_text_tokenizer_core
  import stt_pkg::*;
#(
  parameter int unsigned POSITION_WIDTH = PositionWidthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  source_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  token_kind_o,
  output logic [15:0] token_start_o,
  output logic [15:0] token_length_o,
  output logic        last_of_run_o
);

  localparam int unsigned PW = POSITION_WIDTH;

  // Scanner state
  scan_mode_e             mode_q, mode_d;
  logic [PW-1:0]          pos_q, pos_d;
  logic [PW-1:0]          start_q, start_d;
  logic [PW-1:0]          len_q, len_d;
  logic [NumKeywords-1:0] mask_q, mask_d;

  // Result queue
  token_t                 queue_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0]   count_q;

  logic                   in_fire, out_fire;
  logic [7:0]             c;
  logic                   len_short;
  logic [PW-1:0]          len_inc;

  // Handling of a byte when no token is open
  logic                   beg_v;
  token_t                 beg_tok;
  scan_mode_e             beg_mode;
  logic [PW-1:0]          beg_start, beg_len;
  logic [NumKeywords-1:0] beg_mask;

  logic                   close_v, use_beg;
  token_t                 close_tok, first_tok;
  logic [1:0]             n_wr;

  assign c         = source_byte_i;
  assign in_fire   = in_valid_i && in_ready_o;
  assign out_fire  = out_valid_o && out_ready_i;
  assign len_short = ((len_q >> 4) == '0);
  assign len_inc   = (len_q == '1) ? len_q : len_q + 1'b1;

  // Start of a new token
  always_comb begin
    beg_v          = 1'b0;
    beg_tok.kind   = KIND_UNKNOWN;
    beg_tok.start  = 16'(pos_q);
    beg_tok.length = 16'd1;
    beg_tok.last   = 1'b1;
    beg_mode       = MODE_IDLE;
    beg_start      = start_q;
    beg_len        = '0;
    beg_mask       = '1;
    if (c == ChrNul) begin
      beg_v          = 1'b1;
      beg_tok.kind   = KIND_END;
      beg_tok.length = 16'd0;
    end else if (is_space(c)) begin
      beg_v = 1'b0;
    end else if (c == ChrSlash) begin
      beg_mode  = MODE_SLASH;
      beg_start = pos_q;
    end else if (is_alpha(c)) begin
      beg_mode  = MODE_IDENT;
      beg_start = pos_q;
      beg_mask  = kw_keep(c, 4'd0, 1'b1);
      beg_len   = PW'(1);
    end else if (c == ChrQuote) begin
      beg_mode  = MODE_STRING;
      beg_start = pos_q + 1'b1;
    end else if (is_digit(c)) begin
      beg_mode  = MODE_NUMBER;
      beg_start = pos_q;
      beg_len   = PW'(1);
    end else begin
      beg_v        = 1'b1;
      beg_tok.kind = sym_kind(c);
    end
  end

  // Per-mode step and next state
  always_comb begin
    close_v          = 1'b0;
    close_tok.kind   = KIND_UNKNOWN;
    close_tok.start  = 16'(start_q);
    close_tok.length = 16'(len_q);
    close_tok.last   = 1'b0;
    use_beg          = 1'b0;
    mode_d           = mode_q;
    start_d          = start_q;
    len_d            = len_q;
    mask_d           = mask_q;

    unique case (mode_q)
      MODE_SLASH: begin
        if (c == ChrSlash) begin
          mode_d = MODE_COMMENT;
        end else begin
          close_v          = 1'b1;
          close_tok.length = 16'd1;
          use_beg          = 1'b1;
        end
      end
      MODE_COMMENT: begin
        if (c == ChrNewline) begin
          mode_d = MODE_IDLE;
        end else if (c == ChrNul) begin
          use_beg = 1'b1;
        end
      end
      MODE_IDENT: begin
        if (is_alpha(c) || is_digit(c)) begin
          mask_d = mask_q & kw_keep(c, len_q[3:0], len_short);
          len_d  = len_inc;
        end else begin
          close_v        = 1'b1;
          close_tok.kind = ident_kind(mask_q, len_q[3:0], len_short);
          use_beg        = 1'b1;
        end
      end
      MODE_NUMBER: begin
        if (is_digit(c)) begin
          len_d = len_inc;
        end else begin
          close_v        = 1'b1;
          close_tok.kind = KIND_NUMBER;
          use_beg        = 1'b1;
        end
      end
      MODE_STRING: begin
        if (c == ChrQuote) begin
          close_v        = 1'b1;
          close_tok.kind = KIND_STRING;
          mode_d         = MODE_IDLE;
          len_d          = '0;
        end else if (c == ChrNul) begin
          close_v        = 1'b1;
          close_tok.kind = KIND_STRING;
          use_beg        = 1'b1;
        end else begin
          len_d = len_inc;
        end
      end
      default: begin
        use_beg = 1'b1;
      end
    endcase

    if (use_beg) begin
      mode_d  = beg_mode;
      start_d = beg_start;
      len_d   = beg_len;
      mask_d  = beg_mask;
    end

    // End of text returns the scanner state to its reset values
    if (c == ChrNul) begin
      mode_d  = MODE_IDLE;
      pos_d   = '0;
      start_d = '0;
      len_d   = '0;
      mask_d  = '1;
    end else begin
      pos_d = pos_q + 1'b1;
    end
  end

  // Tokens produced by this byte, in order
  always_comb begin
    n_wr           = 2'(close_v) + 2'(use_beg && beg_v);
    first_tok      = close_v ? close_tok : beg_tok;
    first_tok.last = (n_wr == 2'd1);
  end

  // Scanner registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      pos_q   <= '0;
      start_q <= '0;
      len_q   <= '0;
      mask_q  <= '1;
    end else if (in_fire) begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      len_q   <= len_d;
      mask_q  <= mask_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (in_fire && (n_wr != 2'd0)) begin
      queue_q[wr_ptr_q] <= first_tok;
      if (n_wr == 2'd2) begin
        queue_q[wr_ptr_q + 1'b1] <= beg_tok;
      end
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (in_fire) begin
        wr_ptr_q <= wr_ptr_q + QueuePtrW'(n_wr);
      end
      if (out_fire) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_q + (in_fire ? QueueCntW'(n_wr) : '0) - QueueCntW'(out_fire);
    end
  end

  assign in_ready_o     = (count_q <= QueueCntW'(QueueDepth - 2));
  assign out_valid_o    = (count_q != '0);
  assign token_kind_o   = queue_q[rd_ptr_q].kind;
  assign token_start_o  = queue_q[rd_ptr_q].start;
  assign token_length_o = queue_q[rd_ptr_q].length;
  assign last_of_run_o  = queue_q[rd_ptr_q].last;

endmodule

// ===== sv/stt_checker.sv =====
// Port-level checks for the source text tokenizer, bound to the top level.
`timescale 1ns / 1ps

module stt_checker
  import stt_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [7:0]  source_byte_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [4:0]  token_kind_o,
  input logic [15:0] token_start_o,
  input logic [15:0] token_length_o,
  input logic        last_of_run_o
);

  // A stalled token holds until its transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(token_kind_o) &&
      $stable(token_start_o) && $stable(token_length_o) && $stable(last_of_run_o))
    else $error("token changed while stalled");

  // Input only backs up when tokens are waiting
  a_ready_backlog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // End token is empty and closes the run of its byte
  a_end_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (token_kind_o == 5'(KIND_END)) |->
      (token_length_o == 16'd0) && last_of_run_o)
    else $error("malformed end token");

  // Symbols are one byte and kinds stay in range
  a_symbol_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (token_kind_o >= 5'(KIND_PLUS)) |->
      (token_length_o == 16'd1) && (token_kind_o <= 5'(KIND_RBRACE)))
    else $error("bad symbol token");

endmodule

bind source_text_tokenizer_core stt_checker u_stt_checker (.*);
